### rtl/sbfd_pkg.sv
// sbfd_pkg: shared types, register indexes and reset constants for the
// single button fade dimmer. No dependencies.
package sbfd_pkg;

  // default width of the saturating millisecond counters
  localparam int TICK_COUNT_BITS_DEF = 16;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_ANIM_PERIOD = 3'd1,
    CFG_LONG_PRESS  = 3'd2,
    CFG_FADE_STEP   = 3'd3,
    CFG_SETUP_STEP  = 3'd4
  } cfg_idx_t;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [15:0] ANIM_PERIOD_RST = 16'd10;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [7:0]  FADE_STEP_RST   = 8'd4;
  localparam logic [7:0]  SETUP_STEP_RST  = 8'd1;

  // brightness limits
  localparam logic [7:0] LEVEL_FULL    = 8'd255;
  localparam logic [7:0] LEVEL_OFF     = 8'd0;
  localparam logic [7:0] MAX_LEVEL_RST = 8'd255;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] animation_period;
    logic [15:0] long_press_ticks;
    logic [7:0]  fade_step;
    logic [7:0]  setup_step;
  } cfg_t;

  // dimmer state apart from the tick counters
  typedef struct packed {
    logic [7:0]        level;
    logic signed [8:0] step;
    logic [7:0]        target_level;
    logic [7:0]        max_level;
    logic              on_flag;
    logic              setup_flag;
    logic              pressed_flag;
    logic              debouncing_flag;
  } dim_state_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic       lamp_on;
    logic       in_setup;
    logic       button_held;
    logic [7:0] stored_max;
  } result_t;

endpackage

### rtl/sbfd_if.sv
// sbfd_if: valid/ready channel interfaces for tick input, result output
// and configuration writes. Depends on sbfd_pkg.

// tick input channel
interface sbfd_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

// result output channel
interface sbfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_level;
  logic       lamp_on;
  logic       in_setup;
  logic       button_held;
  logic [7:0] stored_max;
  modport source (output valid, output pwm_level, output lamp_on, output in_setup,
                  output button_held, output stored_max, input ready);
  modport sink (input valid, input pwm_level, input lamp_on, input in_setup,
                input button_held, input stored_max, output ready);
endinterface

// configuration write channel
interface sbfd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbfd_pkg::CFG_IDX_W-1:0]  index;
  logic [sbfd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/sbfd_step.sv
// sbfd_step: next-state logic for one millisecond tick: counters, debounce,
// press/release, long press and animation. Depends on sbfd_pkg.
module sbfd_step #(
  parameter int TICK_COUNT_BITS = sbfd_pkg::TICK_COUNT_BITS_DEF
) (
  input  sbfd_pkg::cfg_t              cfg,
  input  sbfd_pkg::dim_state_t        st,
  input  logic [TICK_COUNT_BITS-1:0]  since_sample,
  input  logic [TICK_COUNT_BITS-1:0]  since_anim,
  input  logic [TICK_COUNT_BITS-1:0]  held_ticks,
  input  logic                        button_level,
  output sbfd_pkg::dim_state_t        st_nxt,
  output logic [TICK_COUNT_BITS-1:0]  since_sample_nxt,
  output logic [TICK_COUNT_BITS-1:0]  since_anim_nxt,
  output logic [TICK_COUNT_BITS-1:0]  held_ticks_nxt
);

  // compare width wide enough for both counters and 16-bit registers
  localparam int CMP_W = TICK_COUNT_BITS + 16;
  localparam logic [TICK_COUNT_BITS-1:0] CNT_SAT = '1;

  logic [TICK_COUNT_BITS-1:0] ss;
  logic [TICK_COUNT_BITS-1:0] sa;
  logic [TICK_COUNT_BITS-1:0] ht;
  logic                       do_sample;
  logic                       now_pressed;
  logic signed [9:0]          moved;
  logic signed [9:0]          target_ext;
  sbfd_pkg::dim_state_t       s;

  always_comb begin
    // saturating tick counters
    ss = (since_sample == CNT_SAT) ? CNT_SAT : since_sample + 1'b1;
    sa = (since_anim == CNT_SAT) ? CNT_SAT : since_anim + 1'b1;
    ht = (held_ticks == CNT_SAT) ? CNT_SAT : held_ticks + 1'b1;
    s  = st;

    // debounced sampling of the active-low pin
    do_sample   = !st.debouncing_flag ||
                  (CMP_W'(ss) >= CMP_W'(cfg.debounce_ticks));
    now_pressed = ~button_level;
    if (do_sample) begin
      if (now_pressed != st.pressed_flag) begin
        ht = '0;
        if (now_pressed) begin
          // press toggles the lamp
          if (st.on_flag) begin
            s.on_flag      = 1'b0;
            s.target_level = sbfd_pkg::LEVEL_OFF;
            s.step         = -$signed({1'b0, cfg.fade_step});
          end else begin
            s.on_flag      = 1'b1;
            s.target_level = st.max_level;
            s.step         = $signed({1'b0, cfg.fade_step});
          end
        end else if (st.setup_flag) begin
          // release ends the sweep and keeps the level as the new maximum
          s.setup_flag = 1'b0;
          s.max_level  = st.level;
          s.step       = '0;
        end
        s.pressed_flag    = now_pressed;
        s.debouncing_flag = 1'b1;
      end else begin
        s.debouncing_flag = 1'b0;
      end
      ss = '0;
    end

    // long press starts the setup sweep
    if (s.pressed_flag && !s.setup_flag &&
        (CMP_W'(ht) > CMP_W'(cfg.long_press_ticks))) begin
      s.setup_flag = 1'b1;
      if (s.level == sbfd_pkg::LEVEL_OFF) begin
        s.step         = $signed({1'b0, cfg.setup_step});
        s.target_level = sbfd_pkg::LEVEL_FULL;
      end else begin
        s.step         = -$signed({1'b0, cfg.setup_step});
        s.target_level = sbfd_pkg::LEVEL_OFF;
      end
    end

    // animation step, clamped to the target
    moved      = $signed({2'b00, s.level}) + $signed({s.step[8], s.step});
    target_ext = $signed({2'b00, s.target_level});
    if (CMP_W'(sa) >= CMP_W'(cfg.animation_period)) begin
      sa = '0;
      if (s.step != '0) begin
        if ((!s.step[8] && (moved > target_ext)) ||
            (s.step[8] && (moved < target_ext))) begin
          s.level = s.target_level;
          if (s.setup_flag) begin
            s.target_level = s.step[8] ? sbfd_pkg::LEVEL_FULL : sbfd_pkg::LEVEL_OFF;
            s.step         = -s.step;
          end else begin
            s.step = '0;
          end
        end else begin
          s.level = moved[7:0];
        end
      end
    end

    st_nxt           = s;
    since_sample_nxt = ss;
    since_anim_nxt   = sa;
    held_ticks_nxt   = ht;
  end

endmodule

### rtl/single_button_fade_dimmer.sv
// single_button_fade_dimmer: top level with input register, tick state,
// result register and configuration registers.
// Depends on sbfd_pkg, sbfd_if and sbfd_step.
// A tick word passes through the input register and then the result register,
// where its result word waits until the output channel takes it.
// Throughput: one tick word per cycle while the result side does not stall;
// the single tick-state update is the only loop.
// Reset (rst_n low, synchronous): state and registers to their defaults,
// both pipeline stages empty.
module single_button_fade_dimmer #(
  parameter int TICK_COUNT_BITS = sbfd_pkg::TICK_COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sbfd_in_if.sink    in_chan,
  sbfd_out_if.source out_chan,
  sbfd_cfg_if.sink   cfg_chan
);

  sbfd_pkg::cfg_t       cfg_r;
  sbfd_pkg::dim_state_t st_r;
  sbfd_pkg::dim_state_t st_nxt;
  sbfd_pkg::result_t    res_r;

  logic [TICK_COUNT_BITS-1:0] since_sample_r, since_sample_nxt;
  logic [TICK_COUNT_BITS-1:0] since_anim_r, since_anim_nxt;
  logic [TICK_COUNT_BITS-1:0] held_ticks_r, held_ticks_nxt;

  logic s1_valid_r;
  logic s1_button_r;
  logic out_valid_r;
  logic s2_take;
  logic s1_fire;
  logic in_fire;

  // handshake: result register can take a word when empty or draining
  assign s2_take       = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && s2_take;
  assign in_chan.ready = !s1_valid_r || s2_take;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= sbfd_pkg::DEBOUNCE_RST;
      cfg_r.animation_period <= sbfd_pkg::ANIM_PERIOD_RST;
      cfg_r.long_press_ticks <= sbfd_pkg::LONG_PRESS_RST;
      cfg_r.fade_step        <= sbfd_pkg::FADE_STEP_RST;
      cfg_r.setup_step       <= sbfd_pkg::SETUP_STEP_RST;
    end else if (cfg_chan.valid) begin
      unique case (sbfd_pkg::cfg_idx_t'(cfg_chan.index))
        sbfd_pkg::CFG_DEBOUNCE:    cfg_r.debounce_ticks   <= cfg_chan.data;
        sbfd_pkg::CFG_ANIM_PERIOD: cfg_r.animation_period <= cfg_chan.data;
        sbfd_pkg::CFG_LONG_PRESS:  cfg_r.long_press_ticks <= cfg_chan.data;
        sbfd_pkg::CFG_FADE_STEP:   cfg_r.fade_step        <= cfg_chan.data[7:0];
        sbfd_pkg::CFG_SETUP_STEP:  cfg_r.setup_step       <= cfg_chan.data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_button_r <= in_chan.button_level;
    end
  end

  // tick update logic
  sbfd_step #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_step (
    .cfg              (cfg_r),
    .st               (st_r),
    .since_sample     (since_sample_r),
    .since_anim       (since_anim_r),
    .held_ticks       (held_ticks_r),
    .button_level     (s1_button_r),
    .st_nxt           (st_nxt),
    .since_sample_nxt (since_sample_nxt),
    .since_anim_nxt   (since_anim_nxt),
    .held_ticks_nxt   (held_ticks_nxt)
  );

  // dimmer state, advanced once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.level           <= sbfd_pkg::LEVEL_OFF;
      st_r.step            <= '0;
      st_r.target_level    <= sbfd_pkg::LEVEL_OFF;
      st_r.max_level       <= sbfd_pkg::MAX_LEVEL_RST;
      st_r.on_flag         <= 1'b0;
      st_r.setup_flag      <= 1'b0;
      st_r.pressed_flag    <= 1'b0;
      st_r.debouncing_flag <= 1'b0;
      since_sample_r       <= '0;
      since_anim_r         <= '0;
      held_ticks_r         <= '0;
    end else if (s1_fire) begin
      st_r           <= st_nxt;
      since_sample_r <= since_sample_nxt;
      since_anim_r   <= since_anim_nxt;
      held_ticks_r   <= held_ticks_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r.pwm_level   <= st_nxt.level;
      res_r.lamp_on     <= st_nxt.on_flag;
      res_r.in_setup    <= st_nxt.setup_flag;
      res_r.button_held <= st_nxt.pressed_flag;
      res_r.stored_max  <= st_nxt.max_level;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pwm_level   = res_r.pwm_level;
  assign out_chan.lamp_on     = res_r.lamp_on;
  assign out_chan.in_setup    = res_r.in_setup;
  assign out_chan.button_held = res_r.button_held;
  assign out_chan.stored_max  = res_r.stored_max;

  // setup sweep only runs while the debounced button is held
  a_setup_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.setup_flag |-> st_r.pressed_flag)
    else $error("setup sweep active without a held button");

  // sweep always heads for one end of the range
  a_setup_target_end: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.setup_flag |-> (st_r.target_level == sbfd_pkg::LEVEL_OFF ||
                         st_r.target_level == sbfd_pkg::LEVEL_FULL))
    else $error("setup sweep target not at an end of the range");

  // a stalled input word stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_take) |=> (s1_valid_r && $stable(s1_button_r)))
    else $error("input register lost a stalled word");

endmodule

### bench/dimmer_checker.sv
// dimmer_checker: watches the tick, result and register channels of the fade dimmer,
// predicts every result word and compares it field by field.
// Depends on sbfd_pkg and sbfd_if.
`timescale 1ns / 100ps

module dimmer_checker (
  input  logic clk,
  input  logic rst_n,
  sbfd_in_if   in_mon,
  sbfd_out_if  out_mon,
  sbfd_cfg_if  cfg_mon,
  output int   fail_count,
  output int   words_outstanding
);
  import sbfd_pkg::*;

  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  // predictor copy of registers, dimmer state and millisecond counters
  cfg_t        regs;
  dim_state_t  dim;
  logic [15:0] since_sample;
  logic [15:0] since_anim;
  logic [15:0] held_ticks;
  result_t     dimmer_words_due[$];
  int          mismatches = 0;

  function automatic logic [15:0] bump(input logic [15:0] count);
    return (count == TICK_SAT) ? count : count + 16'd1;
  endfunction

  // register write, masked to the register width; unknown indexes dropped
  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_DEBOUNCE:    regs.debounce_ticks = value;
      CFG_ANIM_PERIOD: regs.animation_period = value;
      CFG_LONG_PRESS:  regs.long_press_ticks = value;
      CFG_FADE_STEP:   regs.fade_step = value[7:0];
      CFG_SETUP_STEP:  regs.setup_step = value[7:0];
      default: ;
    endcase
  endfunction

  // one millisecond tick: counters, button sample, long press, animation
  function automatic result_t advance_tick(input logic pin);
    logic    now_pressed;
    int      next_level;
    result_t word;
    since_sample = bump(since_sample);
    since_anim   = bump(since_anim);
    held_ticks   = bump(held_ticks);

    // debounced sampling, pin is active low
    if (!dim.debouncing_flag || since_sample >= regs.debounce_ticks) begin
      now_pressed = ~pin;
      if (now_pressed != dim.pressed_flag) begin
        held_ticks = '0;
        if (now_pressed) begin
          dim.on_flag = ~dim.on_flag;
          if (dim.on_flag) begin
            dim.target_level = dim.max_level;
            dim.step = $signed({1'b0, regs.fade_step});
          end else begin
            dim.target_level = LEVEL_OFF;
            dim.step = -$signed({1'b0, regs.fade_step});
          end
        end else if (dim.setup_flag) begin
          dim.setup_flag = 1'b0;
          dim.max_level = dim.level;
          dim.step = '0;
        end
        dim.pressed_flag = now_pressed;
        dim.debouncing_flag = 1'b1;
      end else begin
        dim.debouncing_flag = 1'b0;
      end
      since_sample = '0;
    end

    // long hold starts the setup sweep
    if (dim.pressed_flag && !dim.setup_flag && held_ticks > regs.long_press_ticks) begin
      dim.setup_flag = 1'b1;
      if (dim.level == LEVEL_OFF) begin
        dim.step = $signed({1'b0, regs.setup_step});
        dim.target_level = LEVEL_FULL;
      end else begin
        dim.step = -$signed({1'b0, regs.setup_step});
        dim.target_level = LEVEL_OFF;
      end
    end

    // animation step with clamp at the target
    if (since_anim >= regs.animation_period) begin
      since_anim = '0;
      if (dim.step != 0) begin
        next_level = int'(dim.level) + int'(dim.step);
        if (dim.step > 0) begin
          if (next_level > int'(dim.target_level)) begin
            dim.level = dim.target_level;
            if (dim.setup_flag) begin
              dim.step = -dim.step;
              dim.target_level = LEVEL_OFF;
            end else begin
              dim.step = '0;
            end
          end else begin
            dim.level = next_level[7:0];
          end
        end else begin
          if (next_level < int'(dim.target_level)) begin
            dim.level = dim.target_level;
            if (dim.setup_flag) begin
              dim.step = -dim.step;
              dim.target_level = LEVEL_FULL;
            end else begin
              dim.step = '0;
            end
          end else begin
            dim.level = next_level[7:0];
          end
        end
      end
    end

    word.pwm_level   = dim.level;
    word.lamp_on     = dim.on_flag;
    word.in_setup    = dim.setup_flag;
    word.button_held = dim.pressed_flag;
    word.stored_max  = dim.max_level;
    return word;
  endfunction

  // sample all three channels at each edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs.debounce_ticks   = DEBOUNCE_RST;
      regs.animation_period = ANIM_PERIOD_RST;
      regs.long_press_ticks = LONG_PRESS_RST;
      regs.fade_step        = FADE_STEP_RST;
      regs.setup_step       = SETUP_STEP_RST;
      dim.level            = LEVEL_OFF;
      dim.step             = '0;
      dim.target_level     = LEVEL_OFF;
      dim.max_level        = MAX_LEVEL_RST;
      dim.on_flag          = 1'b0;
      dim.setup_flag       = 1'b0;
      dim.pressed_flag     = 1'b0;
      dim.debouncing_flag  = 1'b0;
      since_sample = '0;
      since_anim   = '0;
      held_ticks   = '0;
      dimmer_words_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        write_register(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready)
        dimmer_words_due.push_back(advance_tick(in_mon.button_level));
      if (out_mon.valid && out_mon.ready) begin
        got.pwm_level   = out_mon.pwm_level;
        got.lamp_on     = out_mon.lamp_on;
        got.in_setup    = out_mon.in_setup;
        got.button_held = out_mon.button_held;
        got.stored_max  = out_mon.stored_max;
        if (dimmer_words_due.size() == 0) begin
          $error("result word with no tick outstanding");
          mismatches++;
        end else begin
          want = dimmer_words_due.pop_front();
          if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %0d, got %0d", want.pwm_level, got.pwm_level);
            mismatches++;
          end
          if (got.lamp_on !== want.lamp_on) begin
            $error("lamp_on: expected %0b, got %0b", want.lamp_on, got.lamp_on);
            mismatches++;
          end
          if (got.in_setup !== want.in_setup) begin
            $error("in_setup: expected %0b, got %0b", want.in_setup, got.in_setup);
            mismatches++;
          end
          if (got.button_held !== want.button_held) begin
            $error("button_held: expected %0b, got %0b", want.button_held, got.button_held);
            mismatches++;
          end
          if (got.stored_max !== want.stored_max) begin
            $error("stored_max: expected %0d, got %0d", want.stored_max, got.stored_max);
            mismatches++;
          end
        end
      end
    end
    words_outstanding <= dimmer_words_due.size();
    fail_count <= mismatches;
  end

endmodule

### bench/testbench.sv
// testbench: drives button ticks and register writes into the fade dimmer,
// stalls the result side at random and gives the verdict.
// Depends on sbfd_pkg, sbfd_if, single_button_fade_dimmer and dimmer_checker.
`timescale 1ns / 100ps

module testbench;
  import sbfd_pkg::*;

  // indexes outside the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  bit         steady = 1'b0;
  int         fail_count;
  int         words_outstanding;
  reg_write_t write_list[$];

  sbfd_in_if  in_chan ();
  sbfd_out_if out_chan ();
  sbfd_cfg_if cfg_chan ();

  single_button_fade_dimmer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  dimmer_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_chan),
    .out_mon           (out_chan),
    .cfg_mon           (cfg_chan),
    .fail_count        (fail_count),
    .words_outstanding (words_outstanding)
  );

  always #6 clk = ~clk;

  // result side stalls at random, about 9 times in a hundred
  always @(posedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= 9);
  end

  // watchdog
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  // one tick word, with an occasional random gap first
  task automatic send_tick(input logic pin);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.button_level <= pin;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // hold off ticks until every result has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back to back register writes from the list
  task automatic commit_writes();
    foreach (write_list[k]) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= write_list[k].idx;
      cfg_chan.data  <= write_list[k].data;
      do @(posedge clk); while (!cfg_chan.ready);
    end
    cfg_chan.valid <= 1'b0;
    write_list.delete();
  endtask

  // short timings so presses, holds and sweeps all happen within a phase
  task automatic random_settings();
    write_list.push_back('{CFG_DEBOUNCE, 16'($urandom_range(0, 4))});
    write_list.push_back('{CFG_ANIM_PERIOD, 16'($urandom_range(0, 3))});
    write_list.push_back('{CFG_LONG_PRESS, 16'($urandom_range(0, 30))});
    write_list.push_back('{CFG_FADE_STEP,
                           {8'($urandom_range(0, 255)), 8'($urandom_range(1, 255))}});
    write_list.push_back('{CFG_SETUP_STEP,
                           {8'($urandom_range(0, 255)), 8'($urandom_range(1, 255))}});
    commit_writes();
  endtask

  // mostly press and release runs with some chatter, the rest pin noise
  task automatic run_random_phase(input int budget);
    int sent;
    int hold;
    int rest;
    int chatter;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        send_tick(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        chatter = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
        hold = $urandom_range(1, 40);
        rest = $urandom_range(1, 20);
        repeat (chatter) begin
          send_tick(PIN_PRESSED);
          send_tick(PIN_RELEASED);
        end
        repeat (hold) send_tick(PIN_PRESSED);
        repeat (rest) send_tick(PIN_RELEASED);
        sent += 2 * chatter + hold + rest;
      end
      if ($urandom_range(0, 99) < 3) drain();
    end
    drain();
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.button_level = PIN_RELEASED;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_DEBOUNCE;
    cfg_chan.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timings: a press taken at once, its release masked by the debounce time
    repeat (2) send_tick(PIN_RELEASED);
    repeat (4) send_tick(PIN_PRESSED);
    repeat (2) send_tick(PIN_RELEASED);
    drain();

    // fastest timings, full steps, writes to unused indexes
    write_list.push_back('{CFG_DEBOUNCE, 16'd0});
    write_list.push_back('{CFG_ANIM_PERIOD, 16'd0});
    write_list.push_back('{CFG_LONG_PRESS, 16'd3});
    write_list.push_back('{CFG_FADE_STEP, 16'd255});
    write_list.push_back('{CFG_SETUP_STEP, 16'd255});
    write_list.push_back('{CFG_UNUSED_LO, 16'hFFFF});
    write_list.push_back('{CFG_UNUSED_HI, 16'hFFFF});
    commit_writes();
    send_tick(PIN_RELEASED);
    repeat (6) send_tick(PIN_PRESSED);
    repeat (2) send_tick(PIN_RELEASED);
    send_tick(PIN_PRESSED);
    send_tick(PIN_RELEASED);
    send_tick(PIN_PRESSED);
    send_tick(PIN_RELEASED);
    drain();

    // fade step of zero, high byte discarded
    write_list.push_back('{CFG_FADE_STEP, 16'hFF00});
    commit_writes();
    send_tick(PIN_PRESSED);
    send_tick(PIN_RELEASED);
    drain();

    // lower extremes of debounce and long press, smallest nonzero steps
    write_list.push_back('{CFG_DEBOUNCE, 16'd0});
    write_list.push_back('{CFG_ANIM_PERIOD, 16'd1});
    write_list.push_back('{CFG_LONG_PRESS, 16'd0});
    write_list.push_back('{CFG_FADE_STEP, 16'd1});
    write_list.push_back('{CFG_SETUP_STEP, 16'd1});
    commit_writes();
    run_random_phase(70);

    // every-tick animation with the largest steps
    write_list.push_back('{CFG_DEBOUNCE, 16'd1});
    write_list.push_back('{CFG_ANIM_PERIOD, 16'd0});
    write_list.push_back('{CFG_LONG_PRESS, 16'd12});
    write_list.push_back('{CFG_FADE_STEP, 16'hABFF});
    write_list.push_back('{CFG_SETUP_STEP, 16'h54FF});
    commit_writes();
    run_random_phase(70);

    // both steps zero: toggles without any movement
    write_list.push_back('{CFG_FADE_STEP, 16'h5A00});
    write_list.push_back('{CFG_SETUP_STEP, 16'hA500});
    commit_writes();
    run_random_phase(40);

    random_settings();
    run_random_phase(80);
    random_settings();
    steady = 1'b1;
    run_random_phase(80);
    steady = 1'b0;
    random_settings();
    run_random_phase(80);

    // upper extremes of every register with a short hold
    write_list.push_back('{CFG_DEBOUNCE, 16'd0});
    commit_writes();
    repeat (3) send_tick(PIN_RELEASED);
    drain();
    write_list.push_back('{CFG_DEBOUNCE, 16'hFFFF});
    write_list.push_back('{CFG_ANIM_PERIOD, 16'hFFFF});
    write_list.push_back('{CFG_LONG_PRESS, 16'hFFFF});
    write_list.push_back('{CFG_FADE_STEP, 16'hFFFF});
    write_list.push_back('{CFG_SETUP_STEP, 16'hFFFF});
    commit_writes();
    steady = 1'b1;
    repeat (30) send_tick(PIN_PRESSED);
    repeat (3) send_tick(PIN_RELEASED);
    steady = 1'b0;
    drain();

    if (fail_count == 0 && words_outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
